// ----- hw/rtl/mbe_pkg.sv -----
// shared constants and types for the mandelbrot escape-time block
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  // coordinate format: signed, INT_BITS integer bits
  localparam int COORD_WIDTH  = 48;
  localparam int INT_BITS     = 12;
  localparam int FRAC_BITS    = COORD_WIDTH - INT_BITS;

  // field and register widths
  localparam int STEP_W       = 40;
  localparam int SIDE_W       = 13;
  localparam int PIX_W        = 12;
  localparam int ITER_W       = 12;
  localparam int ESC_W        = 10;
  localparam int MAX_SIDE     = 4096;
  localparam int MAX_ITER_CAP = 4095;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = (COORD_WIDTH > STEP_W) ? COORD_WIDTH : STEP_W;

  // multiplier chunking
  localparam int MUL_W        = (COORD_WIDTH + 1) / 2;
  localparam int COORD_CH     = (COORD_WIDTH + MUL_W - 1) / MUL_W;
  localparam int STEP_CH      = (STEP_W + MUL_W - 1) / MUL_W;
  localparam int OP_CH        = (COORD_CH > STEP_CH) ? COORD_CH : STEP_CH;
  localparam int OP_W         = OP_CH * MUL_W;
  localparam int CH_W         = (OP_CH > 2) ? 2 : 1;
  localparam int SH_W         = CH_W + 1;

  // full-width products and derived widths
  localparam int PROD_W       = 2 * COORD_WIDTH;
  localparam int DIFF_W       = PROD_W + 1;
  localparam int WIDE_W       = PROD_W + 2;
  localparam int RE_W         = DIFF_W - FRAC_BITS;
  localparam int IM_W         = DIFF_W - FRAC_BITS + 1;
  localparam int OFS_W        = PIX_W + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [PROD_W-1:0]             prod_t;
  typedef logic [OP_W-1:0]               op_t;

  // request to the shared multiply-accumulate unit
  typedef struct packed {
    logic            go;
    logic [CH_W-1:0] a_last;
    logic [CH_W-1:0] b_last;
  } mac_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mbe_mac.sv -----
// shared chunked multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none

module mbe_mac (
  input  logic              clk,
  input  logic              rst,
  input  mbe_pkg::mac_req_t req,
  input  mbe_pkg::op_t      op_a,
  input  mbe_pkg::op_t      op_b,
  output logic              done,
  output mbe_pkg::prod_t    acc
);
  import mbe_pkg::*;

  logic                 busy;
  logic [CH_W-1:0]      ia;
  logic [CH_W-1:0]      ib;
  logic [CH_W-1:0]      a_last;
  logic [CH_W-1:0]      b_last;
  logic [2*MUL_W-1:0]   prod;
  logic [2*MUL_W-1:0]   pp;
  logic [SH_W-1:0]      pp_sh;
  logic                 pp_vld;
  logic                 pp_last;
  logic                 last_pair;
  prod_t                acc_add;

  // one chunk pair per cycle
  assign prod      = op_a[ia*MUL_W +: MUL_W] * op_b[ib*MUL_W +: MUL_W];
  assign last_pair = (ia == a_last) && (ib == b_last);
  assign acc_add   = prod_t'(pp) << (pp_sh * MUL_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ia     <= '0;
      ib     <= '0;
      a_last <= '0;
      b_last <= '0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= pp_vld && pp_last;
      pp_vld <= busy;
      if (req.go) begin
        busy   <= 1'b1;
        ia     <= '0;
        ib     <= '0;
        a_last <= req.a_last;
        b_last <= req.b_last;
      end else if (busy) begin
        if (ib == b_last) begin
          ib <= '0;
          if (ia == a_last) begin
            busy <= 1'b0;
          end else begin
            ia <= ia + 1'b1;
          end
        end else begin
          ib <= ib + 1'b1;
        end
      end
    end
  end

  // product register, then accumulate
  always_ff @(posedge clk) begin
    pp      <= prod;
    pp_sh   <= SH_W'(ia) + SH_W'(ib);
    pp_last <= last_pair;
    if (req.go) begin
      acc <= '0;
    end else if (pp_vld) begin
      acc <= acc + acc_add;
    end
  end

  a_go_idle : assert property (@(posedge clk) disable iff (rst)
    req.go |-> !busy)
    else $error("mac started while busy");

  a_go_clears : assert property (@(posedge clk) disable iff (rst)
    req.go |=> busy && (ia == '0) && (ib == '0) && !done)
    else $error("mac start did not reset the chunk counters");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !pp_vld)
    else $error("mac done while products still pending");

endmodule

`default_nettype wire

// ----- hw/rtl/mandelbrot_escape_time.sv -----
// mandelbrot escape-time counter: sequencer, datapath and configuration registers
// each iteration runs three chunked products through the one shared multiplier
// throughput: one word at a time; busy stays high until the cycle of the done strobe
// the result is shown for one cycle on done/iter_count; the receiver cannot stall
// reset (rst, synchronous): sequencer idle, registers take their default view settings
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                             start,
  output logic                             busy,
  input  logic [mbe_pkg::PIX_W-1:0]        pixel_row,
  input  logic [mbe_pkg::PIX_W-1:0]        pixel_col,
  output logic                             done,
  output logic [mbe_pkg::ITER_W-1:0]       iter_count
);
  import mbe_pkg::*;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = CFG_IDX_W'(6);

  // default view: centre -0.65 + 0i, 2.5/3072 per pixel, 4096 x 3072
  localparam coord_t              CENTER_X_RST   = COORD_WIDTH'(-64'sd44667659878);
  localparam coord_t              CENTER_Y_RST   = '0;
  localparam logic [STEP_W-1:0]   PIXEL_STEP_RST = STEP_W'(55924053);
  localparam logic [SIDE_W-1:0]   WIDTH_RST      = SIDE_W'(4096);
  localparam logic [SIDE_W-1:0]   HEIGHT_RST     = SIDE_W'(3072);
  localparam logic [ITER_W-1:0]   ITER_RST       = ITER_W'(3000);
  localparam logic [ESC_W-1:0]    ESC_RST        = ESC_W'(100);

  // saturation bounds seen at the wide adder width
  localparam logic signed [WIDE_W-1:0] WIDE_MAX =
    {{(WIDE_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = ~WIDE_MAX;

  typedef enum logic [2:0] {
    IDLE,
    INIT_A,
    INIT_B,
    LAUNCH,
    SQ_X,
    SQ_Y,
    CROSS,
    UPDATE
  } state_t;

  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    coord_t r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[COORD_WIDTH-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] wide_coord(input coord_t v);
    return {{(WIDE_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  // magnitude of a coordinate; the most negative value maps to 2^(w-1)
  function automatic logic [COORD_WIDTH-1:0] coord_mag(input coord_t v);
    return v[COORD_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // configuration registers
  coord_t              center_x;
  coord_t              center_y;
  logic [STEP_W-1:0]   pixel_step;
  logic [SIDE_W-1:0]   image_width;
  logic [SIDE_W-1:0]   image_height;
  logic [ITER_W-1:0]   iter_limit;
  logic [ESC_W-1:0]    escape_limit;

  // sequencer
  state_t              state;
  logic [ITER_W-1:0]   k;
  mac_req_t            mac_req;

  // datapath registers
  logic [PIX_W-1:0]    row_r;
  logic                ofs_neg;
  op_t                 op_a;
  op_t                 op_b;
  coord_t              a;
  coord_t              b;
  coord_t              x;
  coord_t              y;
  prod_t               xx;
  logic signed [RE_W-1:0] re_r;
  logic signed [IM_W-1:0] im_r;

  // shared unit
  logic                mac_done;
  prod_t               acc;

  // combinational helpers
  logic [SIDE_W-1:0]   w_cap;
  logic [SIDE_W-1:0]   h_cap;
  logic [ITER_W-1:0]   lim;
  logic [OFS_W-1:0]    col_ofs;
  logic [OFS_W-1:0]    row_ofs;
  logic [OFS_W-1:0]    col_mag;
  logic [OFS_W-1:0]    row_mag;
  coord_t              ctr;
  logic signed [WIDE_W-1:0] start_sum;
  coord_t              start_pt;
  logic [COORD_WIDTH-1:0] mag_x;
  logic [COORD_WIDTH-1:0] mag_y;
  logic [DIFF_W-1:0]   sq_sum;
  logic [DIFF_W-1:0]   bound;
  logic                escaped;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_sh;
  logic                xy_neg;
  logic signed [DIFF_W-1:0] im_full;
  logic signed [DIFF_W-1:0] im_sh;
  logic signed [WIDE_W-1:0] x_sum;
  logic signed [WIDE_W-1:0] y_sum;

  mbe_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .req  (mac_req),
    .op_a (op_a),
    .op_b (op_b),
    .done (mac_done),
    .acc  (acc)
  );

  // size and limit clamps
  assign w_cap = (image_width > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : image_width;
  assign h_cap = (image_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : image_height;
  assign lim   = (iter_limit > ITER_W'(MAX_ITER_CAP)) ? ITER_W'(MAX_ITER_CAP) : iter_limit;

  // pixel offset from the image centre, two's complement
  assign col_ofs = OFS_W'(pixel_col) - OFS_W'(w_cap >> 1);
  assign row_ofs = OFS_W'(row_r) - OFS_W'(h_cap >> 1);
  assign col_mag = col_ofs[OFS_W-1] ? (~col_ofs + 1'b1) : col_ofs;
  assign row_mag = row_ofs[OFS_W-1] ? (~row_ofs + 1'b1) : row_ofs;

  // start point: centre +/- |offset| * step, saturated
  assign ctr       = (state == INIT_A) ? center_x : center_y;
  assign start_sum = ofs_neg ? (wide_coord(ctr) - $signed({2'b00, acc}))
                             : (wide_coord(ctr) + $signed({2'b00, acc}));
  assign start_pt  = sat_coord(start_sum);

  assign mag_x = coord_mag(x);
  assign mag_y = coord_mag(y);

  // escape test against the limit at full product precision
  assign sq_sum  = {1'b0, xx} + {1'b0, acc};
  assign bound   = DIFF_W'(escape_limit) << (2 * FRAC_BITS);
  assign escaped = (sq_sum > bound) || (k >= lim);

  // real part: floor((xx - yy) / 2^f)
  assign diff    = $signed({1'b0, xx}) - $signed({1'b0, acc});
  assign diff_sh = diff >>> FRAC_BITS;

  // imaginary part: floor(2 * x * y / 2^f)
  assign xy_neg  = x[COORD_WIDTH-1] ^ y[COORD_WIDTH-1];
  assign im_full = xy_neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  assign im_sh   = im_full >>> (FRAC_BITS - 1);

  // update adds, c added back with saturation
  assign x_sum = {{(WIDE_W-RE_W){re_r[RE_W-1]}}, re_r} + wide_coord(a);
  assign y_sum = {{(WIDE_W-IM_W){im_r[IM_W-1]}}, im_r} + wide_coord(b);

  assign busy = (state != IDLE);

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= CENTER_X_RST;
      center_y     <= CENTER_Y_RST;
      pixel_step   <= PIXEL_STEP_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      iter_limit   <= ITER_RST;
      escape_limit <= ESC_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CENTER_X:     center_x     <= wr_data[COORD_WIDTH-1:0];
        REG_CENTER_Y:     center_y     <= wr_data[COORD_WIDTH-1:0];
        REG_PIXEL_STEP:   pixel_step   <= wr_data[STEP_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= wr_data[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= wr_data[SIDE_W-1:0];
        REG_ITER_LIMIT:   iter_limit   <= wr_data[ITER_W-1:0];
        REG_ESCAPE_LIMIT: escape_limit <= wr_data[ESC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: state, iteration count, unit requests and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      k          <= '0;
      mac_req    <= '0;
      done       <= 1'b0;
      iter_count <= '0;
    end else begin
      mac_req.go <= 1'b0;
      done       <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            mac_req.go     <= 1'b1;
            mac_req.a_last <= '0;
            mac_req.b_last <= CH_W'(STEP_CH - 1);
            state          <= INIT_A;
          end
        end
        INIT_A: begin
          if (mac_done) begin
            mac_req.go     <= 1'b1;
            mac_req.a_last <= '0;
            mac_req.b_last <= CH_W'(STEP_CH - 1);
            state          <= INIT_B;
          end
        end
        INIT_B: begin
          if (mac_done) begin
            k     <= '0;
            state <= LAUNCH;
          end
        end
        LAUNCH: begin
          mac_req.go     <= 1'b1;
          mac_req.a_last <= CH_W'(COORD_CH - 1);
          mac_req.b_last <= CH_W'(COORD_CH - 1);
          state          <= SQ_X;
        end
        SQ_X: begin
          if (mac_done) begin
            mac_req.go <= 1'b1;
            state      <= SQ_Y;
          end
        end
        SQ_Y: begin
          if (mac_done) begin
            if (escaped) begin
              done       <= 1'b1;
              iter_count <= k;
              state      <= IDLE;
            end else begin
              mac_req.go <= 1'b1;
              state      <= CROSS;
            end
          end
        end
        CROSS: begin
          if (mac_done) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          k     <= k + 1'b1;
          state <= LAUNCH;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // datapath registers, loaded under the sequencer state
  always_ff @(posedge clk) begin
    unique case (state)
      IDLE: begin
        if (start) begin
          row_r   <= pixel_row;
          ofs_neg <= col_ofs[OFS_W-1];
          op_a    <= OP_W'(col_mag);
          op_b    <= OP_W'(pixel_step);
        end
      end
      INIT_A: begin
        if (mac_done) begin
          a       <= start_pt;
          x       <= start_pt;
          ofs_neg <= row_ofs[OFS_W-1];
          op_a    <= OP_W'(row_mag);
          op_b    <= OP_W'(pixel_step);
        end
      end
      INIT_B: begin
        if (mac_done) begin
          b <= start_pt;
          y <= start_pt;
        end
      end
      LAUNCH: begin
        op_a <= OP_W'(mag_x);
        op_b <= OP_W'(mag_x);
      end
      SQ_X: begin
        if (mac_done) begin
          xx   <= acc;
          op_a <= OP_W'(mag_y);
          op_b <= OP_W'(mag_y);
        end
      end
      SQ_Y: begin
        if (mac_done) begin
          re_r <= diff_sh[RE_W-1:0];
          op_a <= OP_W'(mag_x);
          op_b <= OP_W'(mag_y);
        end
      end
      CROSS: begin
        if (mac_done) begin
          im_r <= im_sh[IM_W-1:0];
        end
      end
      UPDATE: begin
        x <= sat_coord(x_sum);
        y <= sat_coord(y_sum);
      end
      default: ;
    endcase
  end

  a_done_from_test : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == SQ_Y) && !busy)
    else $error("result word not issued from the escape test");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted word did not make the block busy");

  a_count_limit : assert property (@(posedge clk) disable iff (rst)
    done |-> iter_count <= lim)
    else $error("iteration count beyond the iteration limit");

  a_mac_done_waiting : assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == INIT_A) || (state == INIT_B) || (state == SQ_X) ||
                 (state == SQ_Y) || (state == CROSS))
    else $error("product finished with no state waiting for it");

endmodule

`default_nettype wire

// ----- tb/sv/mbe_tb_pkg.sv -----
// scoreboard and shared types for the mandelbrot escape-time testbench
`timescale 1ns / 1ps

package mbe_tb_pkg;
  import mbe_pkg::*;

  // configuration register indexes, in port order
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 0,
    REG_CENTER_Y     = 1,
    REG_PIXEL_STEP   = 2,
    REG_IMAGE_WIDTH  = 3,
    REG_IMAGE_HEIGHT = 4,
    REG_ITER_LIMIT   = 5,
    REG_ESCAPE_LIMIT = 6
  } view_reg_e;

  localparam int N_VIEW_REGS = 7;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    logic [PIX_W-1:0]  row;
    logic [PIX_W-1:0]  col;
    logic [ITER_W-1:0] count;
  } pixel_count_t;

  class escape_scoreboard;
    coord_t              view_cx;
    coord_t              view_cy;
    logic [STEP_W-1:0]   step;
    logic [SIDE_W-1:0]   width;
    logic [SIDE_W-1:0]   height;
    logic [ITER_W-1:0]   limit;
    logic [ESC_W-1:0]    esc_bound;
    pixel_count_t        counts_due[$];
    int                  errors = 0;
    int                  compared = 0;
    int                  noted = 0;

    function new();
      reset_view();
    endfunction

    // register contents straight after reset
    function void reset_view();
      view_cx   = -48'sd44667659878;
      view_cy   = '0;
      step      = 40'd55924053;
      width     = 13'd4096;
      height    = 13'd3072;
      limit     = 12'd3000;
      esc_bound = 10'd100;
    endfunction

    // a write keeps only the bits the register holds
    function void set_reg(view_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_X:     view_cx   = data[COORD_WIDTH-1:0];
        REG_CENTER_Y:     view_cy   = data[COORD_WIDTH-1:0];
        REG_PIXEL_STEP:   step      = data[STEP_W-1:0];
        REG_IMAGE_WIDTH:  width     = data[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: height    = data[SIDE_W-1:0];
        REG_ITER_LIMIT:   limit     = data[ITER_W-1:0];
        REG_ESCAPE_LIMIT: esc_bound = data[ESC_W-1:0];
        default: ;
      endcase
    endfunction

    function coord_t clamp_coord(acc_t v);
      coord_t top, bot;
      acc_t   top_w, bot_w;
      top = '1;
      top[COORD_WIDTH-1] = 1'b0;
      bot = '0;
      bot[COORD_WIDTH-1] = 1'b1;
      top_w = top;
      bot_w = bot;
      if (v > top_w) return top;
      if (v < bot_w) return bot;
      return v[COORD_WIDTH-1:0];
    endfunction

    // escape-time count of one pixel under the current view
    function logic [ITER_W-1:0] escape_count(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
      longint cols, rows, lim, k, ofs_x, ofs_y;
      coord_t a, b, x, y;
      acc_t   aw, bw, xw, yw, xx, yy, bound, t;
      cols  = (width > MAX_SIDE) ? MAX_SIDE : width;
      rows  = (height > MAX_SIDE) ? MAX_SIDE : height;
      lim   = (limit > MAX_ITER_CAP) ? MAX_ITER_CAP : limit;
      ofs_x = (longint'(col) - cols / 2) * longint'(step);
      ofs_y = (longint'(row) - rows / 2) * longint'(step);
      t  = ofs_x;
      aw = view_cx;
      a  = clamp_coord(t + aw);
      t  = ofs_y;
      bw = view_cy;
      b  = clamp_coord(t + bw);
      aw = a;
      bw = b;
      bound = esc_bound;
      bound = bound <<< (2 * FRAC_BITS);
      x = a;
      y = b;
      k = 0;
      forever begin
        xw = x;
        yw = y;
        xx = xw * xw;
        yy = yw * yw;
        if (k >= lim || xx + yy > bound) break;
        // floor shifts; the cross term is doubled by shifting one bit less
        x = clamp_coord(((xx - yy) >>> FRAC_BITS) + aw);
        y = clamp_coord(((xw * yw) >>> (FRAC_BITS - 1)) + bw);
        k++;
      end
      return ITER_W'(k);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
      pixel_count_t due;
      due.row   = row;
      due.col   = col;
      due.count = escape_count(row, col);
      counts_due.push_back(due);
      noted++;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_count(logic [ITER_W-1:0] got);
      pixel_count_t due;
      if (counts_due.size() == 0) begin
        report_mismatch($sformatf("iter_count %0d with no pixel outstanding", got));
        return;
      end
      due = counts_due.pop_front();
      compared++;
      if (got !== due.count)
        report_mismatch($sformatf("pixel row %0d col %0d: iter_count %0d, predicted %0d",
                                  due.row, due.col, got, due.count));
    endtask
  endclass

endpackage

// ----- tb/sv/tb_mandelbrot_escape_time.sv -----
// testbench top for the mandelbrot escape-time block: directed views, then random ones
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
  import mbe_pkg::*;
  import mbe_tb_pkg::*;

  // longest correct gap between handshakes is one full 4095-iteration pixel;
  // the watchdog allows several times that long
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int RANDOM_VIEWS   = 8;
  localparam int WORDS_PER_VIEW = 25;
  localparam int NOISY_VIEW     = 5;

  localparam longint ONE = longint'(1) <<< FRAC_BITS;
  localparam logic [CFG_DATA_W-1:0] COORD_TOP    = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam logic [CFG_DATA_W-1:0] COORD_BOTTOM = longint'(1) << (COORD_WIDTH - 1);
  localparam logic [CFG_DATA_W-1:0] STEP_TOP     = (longint'(1) << STEP_W) - 1;

  // every input of the block is known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data = '0;
  logic                   start = 1'b0;
  logic [PIX_W-1:0]       pixel_row = '0;
  logic [PIX_W-1:0]       pixel_col = '0;
  logic                   busy;
  logic                   done;
  logic [ITER_W-1:0]      iter_count;

  escape_scoreboard       sb;
  logic [CFG_DATA_W-1:0]  view_word [N_VIEW_REGS];
  int                     burst_left = 0;
  bit                     steady = 1'b0;
  int                     views_applied = 0;
  int                     idle_cycles = 0;

  mandelbrot_escape_time i_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .start      (start),
    .busy       (busy),
    .pixel_row  (pixel_row),
    .pixel_col  (pixel_col),
    .done       (done),
    .iter_count (iter_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // every done strobe is a finished word; compare it with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) sb.check_count(iter_count);
  end

  // watchdog: counts cycles with neither a word taken nor a count delivered
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // writes all seven registers back to back; only called with the block idle
  task automatic apply_view;
    for (int i = 0; i < N_VIEW_REGS; i++) begin
      wr_en    <= 1'b1;
      wr_index <= view_reg_e'(i);
      wr_data  <= view_word[i];
      @(posedge clk);
      sb.set_reg(view_reg_e'(i), view_word[i]);
    end
    wr_en <= 1'b0;
    views_applied++;
  endtask

  task automatic set_view(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                          input logic [CFG_DATA_W-1:0] pstep,
                          input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
                          input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] esc);
    view_word[REG_CENTER_X]     = cx;
    view_word[REG_CENTER_Y]     = cy;
    view_word[REG_PIXEL_STEP]   = pstep;
    view_word[REG_IMAGE_WIDTH]  = cols;
    view_word[REG_IMAGE_HEIGHT] = rows;
    view_word[REG_ITER_LIMIT]   = lim;
    view_word[REG_ESCAPE_LIMIT] = esc;
    apply_view();
  endtask

  // mostly in range, now and then zero or above the clamp
  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(MAX_SIDE + 1, (1 << SIDE_W) - 1);
      default: return $urandom_range(1, MAX_SIDE);
    endcase
  endfunction

  // random view near the interesting part of the plane, or pure noise in every bit
  task automatic pick_view(input bit noisy);
    if (noisy) begin
      for (int i = 0; i < N_VIEW_REGS; i++) view_word[i] = {$urandom, $urandom};
      // junk stays above the limit field; the count is kept short
      view_word[REG_ITER_LIMIT][ITER_W-1:0] = ITER_W'($urandom_range(0, 40));
    end else begin
      // centre real part in about [-2.5, 1], imaginary in [-1, 1]
      view_word[REG_CENTER_X] = ((longint'($urandom_range(0, 3584)) - 2560) <<< 26)
                                + $urandom_range(0, (1 << 26) - 1);
      view_word[REG_CENTER_Y] = ((longint'($urandom_range(0, 2048)) - 1024) <<< 26)
                                + $urandom_range(0, (1 << 26) - 1);
      // whole field spans at most a few units
      view_word[REG_PIXEL_STEP]   = longint'($urandom_range(1, 4095)) << $urandom_range(10, 14);
      view_word[REG_IMAGE_WIDTH]  = pick_side();
      view_word[REG_IMAGE_HEIGHT] = pick_side();
      view_word[REG_ITER_LIMIT]   = $urandom_range(1, 40);
      view_word[REG_ESCAPE_LIMIT] = $urandom_range(0, 1) ? 4 : $urandom_range(1, 1023);
    end
    apply_view();
  endtask

  // offers one word and holds it until taken; bursts of random length,
  // then a random gap with start low unless the phase runs steady
  task automatic send_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
    int gap;
    start     <= 1'b1;
    pixel_row <= row;
    pixel_col <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(row, col);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = steady ? 0 : $urandom_range(0, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // block goes idle once every predicted count has come back
  task automatic wait_drained;
    start <= 1'b0;
    @(posedge clk);
    while (sb.counts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset view: corners and the far left of the real axis all escape quickly
    send_pixel(0, 0);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(4095, 4095);
    send_pixel(1536, 0);
    wait_drained();

    // extreme registers: width above the clamp, height zero, start points saturate
    set_view(COORD_TOP, COORD_BOTTOM, STEP_TOP, 8191, 0, 4095, 1023);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2048, 2048);
    send_pixel(0, 4095);
    wait_drained();

    // zero step and centre: c is the origin, so the full iteration cap is reached
    set_view(0, 0, 0, MAX_SIDE, MAX_SIDE, MAX_ITER_CAP, 1);
    send_pixel(4095, 0);
    wait_drained();

    // iteration limit zero gives a zero count everywhere
    set_view(-ONE / 2, ONE / 4, 1 << 20, 1, 1, 0, 100);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(1234, 2047);
    wait_drained();

    // escape limit zero: only the origin keeps iterating
    set_view(0, 0, 1 << 26, 2, 3, 33, 0);
    send_pixel(1, 1);
    send_pixel(0, 1);
    send_pixel(4095, 4095);
    send_pixel(2, 1);
    wait_drained();

    // unit grid around c = 1: |z|^2 exactly on the bound, an orbit of period two, pixels past the edge
    set_view(ONE, 0, ONE, 4, 2, 20, 1);
    send_pixel(1, 2);
    send_pixel(1, 0);
    send_pixel(1, 4);
    send_pixel(0, 2);
    send_pixel(4095, 0);
    wait_drained();

    // random views, some with no gaps, one with noise in every register bit
    for (int v = 0; v < RANDOM_VIEWS; v++) begin
      pick_view(v == NOISY_VIEW);
      steady = (v % 3 == 1);
      for (int n = 0; n < WORDS_PER_VIEW; n++)
        send_pixel($urandom_range(0, (1 << PIX_W) - 1), $urandom_range(0, (1 << PIX_W) - 1));
      wait_drained();
    end

    $display("covered %0d register views, %0d pixels sent, %0d counts compared",
             views_applied, sb.noted, sb.compared);
    $display("mismatches %0d, counts still outstanding %0d", sb.errors, sb.counts_due.size());
    if (sb.errors == 0 && sb.counts_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
